// ===== hw/rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP responder: command format between
// the front and back parts, ARP field values, register and request codes.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 2;
  localparam int PTR_W                 = $clog2(QUEUE_DEPTH);
  localparam int PAYLOAD_LEN           = 28;
  localparam int APB_ADDR_W            = 4;
  localparam int APB_DATA_W            = 64;

  localparam logic [5:0] HDR_LEN   = 6'd14;
  localparam logic [5:0] MIN_FRAME = 6'd42;

  // arp field values
  localparam logic [7:0] HTYPE_HI   = 8'h00;
  localparam logic [7:0] HTYPE_LO   = 8'h01;
  localparam logic [7:0] PTYPE_HI   = 8'h08;
  localparam logic [7:0] PTYPE_LO   = 8'h00;
  localparam logic [7:0] OPER_HI    = 8'h00;
  localparam logic [7:0] OP_REQUEST = 8'h01;
  localparam logic [7:0] OP_REPLY   = 8'h02;
  localparam logic [7:0] HLEN_ETH   = 8'd6;
  localparam logic [7:0] PLEN_IPV4  = 8'd4;

  // request and result codes
  localparam logic REQ_FRAME  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;
  localparam logic RES_REPLY  = 1'b0;
  localparam logic RES_LOOKUP = 1'b1;
  localparam logic CMD_FRAME  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // register index, taken from paddr bit 3
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        reply;
    logic [31:0] ip;
    logic [47:0] mac;
  } cmd_t;

endpackage

// ===== hw/rtl/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/arpc_front.sv =====
// ----------------------------------------------------------------------------
// arpc_front
// Counts frame bytes, picks out the ARP header fields and classifies each
// request; a lookup or a full valid ARP frame becomes a back-part command.
// ----------------------------------------------------------------------------
module arpc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 req_type,
  input  logic [7:0]           frame_byte,
  input  logic                 frame_last,
  input  logic [31:0]          query_ip,
  input  logic [31:0]          own_ip,
  output logic                 push,
  output arpc_pkg::cmd_t       cmd
);
  import arpc_pkg::*;

  logic [5:0]  byte_count;
  logic        hdr_ok;
  logic        op_ok;
  logic [47:0] snd_mac;
  logic [31:0] snd_ip;
  logic [31:0] tgt_ip;
  logic        take;
  logic        in_payload;
  logic [4:0]  offset;
  logic [31:0] tgt_cur;
  logic        full_at_end;

  assign take        = accept && (req_type == REQ_FRAME);
  assign in_payload  = (byte_count >= HDR_LEN) && (byte_count < MIN_FRAME);
  assign offset      = 5'(byte_count - HDR_LEN);
  assign full_at_end = byte_count >= (MIN_FRAME - 6'd1);
  assign tgt_cur     = (take && in_payload && offset >= 5'd24) ?
                       {tgt_ip[23:0], frame_byte} : tgt_ip;

  always_comb begin
    push = accept && ((req_type == REQ_LOOKUP) || (frame_last && full_at_end && hdr_ok));
    cmd.kind  = (req_type == REQ_LOOKUP) ? CMD_LOOKUP : CMD_FRAME;
    cmd.reply = (req_type == REQ_FRAME) && op_ok && (tgt_cur == own_ip);
    cmd.ip    = (req_type == REQ_LOOKUP) ? query_ip : snd_ip;
    cmd.mac   = snd_mac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (take) begin
      if (frame_last) begin
        byte_count <= '0;
      end else if (byte_count < MIN_FRAME) begin
        byte_count <= byte_count + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_payload) begin
      case (offset)
        5'd0: hdr_ok <= (frame_byte == HTYPE_HI);
        5'd1: hdr_ok <= hdr_ok && (frame_byte == HTYPE_LO);
        5'd2: hdr_ok <= hdr_ok && (frame_byte == PTYPE_HI);
        5'd3: hdr_ok <= hdr_ok && (frame_byte == PTYPE_LO);
        5'd6: op_ok  <= (frame_byte == OPER_HI);
        5'd7: op_ok  <= op_ok && (frame_byte == OP_REQUEST);
        default: begin
          if (offset >= 5'd8 && offset <= 5'd13) begin
            snd_mac <= {snd_mac[39:0], frame_byte};
          end
          if (offset >= 5'd14 && offset <= 5'd17) begin
            snd_ip <= {snd_ip[23:0], frame_byte};
          end
        end
      endcase
      tgt_ip <= tgt_cur;
    end
  end

endmodule

// ===== hw/rtl/arpc_queue.sv =====
// ----------------------------------------------------------------------------
// arpc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module arpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  arpc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output arpc_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import arpc_pkg::*;

  localparam int CNT_W = PTR_W + 1;

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");
`endif

endmodule

// ===== hw/rtl/arpc_back.sv =====
// ----------------------------------------------------------------------------
// arpc_back
// Carries out queued commands: scans the address cache one entry a cycle,
// stores sender bindings, answers lookups and streams the ARP reply.
// ----------------------------------------------------------------------------
module arpc_back #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  arpc_pkg::cmd_t head,
  output logic           pop,
  input  logic [47:0]    own_mac,
  input  logic [31:0]    own_ip,
  output logic           strobe,
  output logic           result_kind,
  output logic [7:0]     reply_byte,
  output logic [47:0]    reply_dest_mac,
  output logic           reply_last,
  output logic           lookup_hit,
  output logic [47:0]    lookup_mac
);
  import arpc_pkg::*;

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(TABLE_ENTRIES - 1);
  localparam logic [4:0]      LAST_BYTE = 5'(PAYLOAD_LEN - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_REPLY  = 2'd2;

  logic [1:0]               state;
  cmd_t                     cur;
  logic [IDXW-1:0]          scan;
  logic                     issuing;
  logic                     cmp_vld;
  logic [IDXW-1:0]          cmp_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [4:0]               byte_idx;
  logic [79:0]              rd_data;
  logic                     entry_match;
  logic                     done_search;
  logic                     found;
  logic                     ram_we;

  function automatic logic [7:0] reply_byte_at(input logic [4:0] idx,
                                               input logic [47:0] s_mac,
                                               input logic [31:0] s_ip,
                                               input logic [47:0] d_mac,
                                               input logic [31:0] d_ip);
    logic [7:0] b;
    case (idx)
      5'd0:  b = HTYPE_HI;
      5'd1:  b = HTYPE_LO;
      5'd2:  b = PTYPE_HI;
      5'd3:  b = PTYPE_LO;
      5'd4:  b = HLEN_ETH;
      5'd5:  b = PLEN_IPV4;
      5'd6:  b = OPER_HI;
      5'd7:  b = OP_REPLY;
      5'd8:  b = s_mac[47:40];
      5'd9:  b = s_mac[39:32];
      5'd10: b = s_mac[31:24];
      5'd11: b = s_mac[23:16];
      5'd12: b = s_mac[15:8];
      5'd13: b = s_mac[7:0];
      5'd14: b = s_ip[31:24];
      5'd15: b = s_ip[23:16];
      5'd16: b = s_ip[15:8];
      5'd17: b = s_ip[7:0];
      5'd18: b = d_mac[47:40];
      5'd19: b = d_mac[39:32];
      5'd20: b = d_mac[31:24];
      5'd21: b = d_mac[23:16];
      5'd22: b = d_mac[15:8];
      5'd23: b = d_mac[7:0];
      5'd24: b = d_ip[31:24];
      5'd25: b = d_ip[23:16];
      5'd26: b = d_ip[15:8];
      5'd27: b = d_ip[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // a free slot matches only when storing
  assign entry_match = valid[cmp_idx] ? (rd_data[79:48] == cur.ip) : (cur.kind == CMD_FRAME);
  assign done_search = (state == ST_SEARCH) && cmp_vld && (entry_match || cmp_idx == LAST_IDX);
  assign found       = done_search && entry_match;
  assign ram_we      = found && (cur.kind == CMD_FRAME);
  assign pop         = (state == ST_IDLE) && !empty;

  arpc_ram #(
    .WIDTH (80),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDXW)
  ) u_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmp_idx),
    .wdata ({cur.ip, cur.mac}),
    .raddr (scan),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      strobe  <= 1'b0;
      issuing <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            state   <= ST_SEARCH;
            issuing <= 1'b1;
            cmp_vld <= 1'b0;
          end
        end
        ST_SEARCH: begin
          cmp_vld <= issuing;
          if (issuing && scan == LAST_IDX) begin
            issuing <= 1'b0;
          end
          if (done_search) begin
            issuing <= 1'b0;
            cmp_vld <= 1'b0;
            if (cur.kind == CMD_LOOKUP) begin
              strobe <= 1'b1;
              state  <= ST_IDLE;
            end else begin
              if (found) begin
                valid[cmp_idx] <= 1'b1;
              end
              state <= cur.reply ? ST_REPLY : ST_IDLE;
            end
          end
        end
        ST_REPLY: begin
          strobe <= 1'b1;
          if (byte_idx == LAST_BYTE) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      scan <= '0;
    end else if (state == ST_SEARCH && issuing && scan != LAST_IDX) begin
      scan <= scan + 1'b1;
    end
    cmp_idx <= scan;
    if (state == ST_SEARCH) begin
      byte_idx <= '0;
    end else if (state == ST_REPLY) begin
      byte_idx <= byte_idx + 5'd1;
    end
    if (state == ST_REPLY) begin
      result_kind    <= RES_REPLY;
      reply_byte     <= reply_byte_at(byte_idx, own_mac, own_ip, cur.mac, cur.ip);
      reply_dest_mac <= cur.mac;
      reply_last     <= byte_idx == LAST_BYTE;
      lookup_hit     <= 1'b0;
      lookup_mac     <= '0;
    end else begin
      result_kind    <= RES_LOOKUP;
      reply_byte     <= '0;
      reply_dest_mac <= '0;
      reply_last     <= 1'b0;
      lookup_hit     <= found;
      lookup_mac     <= found ? rd_data[47:0] : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_reply_run: assert property (@(posedge clk) disable iff (rst)
    strobe && result_kind == RES_REPLY && !reply_last |=> strobe && result_kind == RES_REPLY)
    else $error("reply stream broken before its last byte");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && reply_last |=> !strobe)
    else $error("result straight after the last reply byte");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && result_kind == RES_LOOKUP && !lookup_hit |-> lookup_mac == '0)
    else $error("lookup miss with non-zero mac");
`endif

endmodule

// ===== hw/rtl/arp_responder_with_cache.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP responder with a small IP-to-MAC cache and an APB register port.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A frame that ends
// as a valid ARP packet, or a lookup query, queues a command (two can wait).
// busy is high while the queue is full, and only then does a request wait.
// The back part runs one command at a time, popping it from the queue in its
// idle state. The cache scan then reads one entry a cycle through a single
// read port. A lookup answer comes out the cycle after the scan ends. A frame
// that was a request for own_ip is followed by its 28 reply bytes. Results
// come one a cycle on strobe and cannot be held off. Cache valid bits clear
// at reset, so no clearing pass is needed.
module arp_responder_with_cache #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [7:0]                      frame_byte,
  input  logic                            frame_last,
  input  logic [31:0]                     query_ip,
  output logic                            strobe,
  output logic                            result_kind,
  output logic [7:0]                      reply_byte,
  output logic [47:0]                     reply_dest_mac,
  output logic                            reply_last,
  output logic                            lookup_hit,
  output logic [47:0]                     lookup_mac,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arpc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [arpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [arpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import arpc_pkg::*;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  cmd_t        push_cmd;
  cmd_t        head;

  assign pready = 1'b1;
  assign busy   = full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3])
        REG_OWN_MAC: own_mac <= pwdata[47:0];
        REG_OWN_IP:  own_ip  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_OWN_MAC: prdata = {16'h0000, own_mac};
      REG_OWN_IP:  prdata = {32'h0000_0000, own_ip};
      default:     prdata = '0;
    endcase
  end

  arpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .frame_byte (frame_byte),
    .frame_last (frame_last),
    .query_ip   (query_ip),
    .own_ip     (own_ip),
    .push       (push),
    .cmd        (push_cmd)
  );

  arpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  arpc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .own_mac        (own_mac),
    .own_ip         (own_ip),
    .strobe         (strobe),
    .result_kind    (result_kind),
    .reply_byte     (reply_byte),
    .reply_dest_mac (reply_dest_mac),
    .reply_last     (reply_last),
    .lookup_hit     (lookup_hit),
    .lookup_mac     (lookup_mac)
  );

endmodule

// ===== tb/arp_responder_with_cache_test.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache_test
// Self-checking bench for the ARP responder. Frame bytes and cache lookups go
// in over start/busy in random bursts. An in-bench model of the capture logic,
// the cache and the reply builder predicts every reply byte and the answer
// to each lookup outside the table below; a scoreboard compares them field
// by field as they come out on strobe. A short table of directed frames and
// lookups covers the corner cases, then random traffic under two settings of
// own_mac/own_ip, written over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int SLOTS          = TABLE_ENTRIES_DEFAULT;
  localparam int DRAIN_CYCLES   = 2 * (SLOTS + 2) + 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE      = 16;
  localparam int NUM_PHASES     = 2;
  localparam int PHASE_FRAMES   = 1;
  localparam int NUM_ROWS       = 10;
  localparam int PRINT_CAP      = 100;

  localparam logic [APB_ADDR_W-1:0] ADDR_OWN_MAC = {REG_OWN_MAC, 3'b000};
  localparam logic [APB_ADDR_W-1:0] ADDR_OWN_IP  = {REG_OWN_IP, 3'b000};

  localparam logic [15:0] ARP_HTYPE = {HTYPE_HI, HTYPE_LO};
  localparam logic [15:0] ARP_PTYPE = {PTYPE_HI, PTYPE_LO};
  localparam logic [15:0] ARP_REQ   = {OPER_HI, OP_REQUEST};
  localparam logic [15:0] ARP_REP   = {OPER_HI, OP_REPLY};

  localparam logic [47:0] OWN_MAC_A = 48'h0200_5e10_2030;
  localparam logic [31:0] OWN_IP_A  = 32'hc0a8_0001;
  localparam logic [47:0] MAC_A     = 48'h0a0b_0c0d_0e0f;
  localparam logic [47:0] MAC_B     = 48'h0c0d_0e0f_1011;
  localparam logic [47:0] MAC_ONES  = 48'hffff_ffff_ffff;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rbyte;
    logic [47:0] dest;
    logic        last;
    logic        hit;
    logic [47:0] mac;
  } arp_res_t;

  // one row: a whole frame, or a lookup of spa
  typedef struct packed {
    logic        lookup;
    logic [6:0]  len;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [15:0] oper;
    logic [47:0] sha;
    logic [31:0] spa;
    logic [31:0] tpa;
    logic [6:0]  q_at;
    logic        typed;
    logic        exp_hit;
    logic [47:0] exp_mac;
  } stim_row_t;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  start          = 1'b0;
  logic                  busy;
  logic                  req_type       = REQ_FRAME;
  logic [7:0]            frame_byte     = 8'h00;
  logic                  frame_last     = 1'b0;
  logic [31:0]           query_ip       = 32'h0;
  logic                  strobe;
  logic                  result_kind;
  logic [7:0]            reply_byte;
  logic [47:0]           reply_dest_mac;
  logic                  reply_last;
  logic                  lookup_hit;
  logic [47:0]           lookup_mac;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  typed_on       = 1'b0;
  arp_res_t              typed_res      = '0;

  // model state
  logic [47:0]           cfg_mac        = '0;
  logic [31:0]           cfg_ip         = '0;
  logic [5:0]            rx_count       = '0;
  logic [7:0]            arp_buf [PAYLOAD_LEN];
  logic [31:0]           slot_ip [SLOTS];
  logic [47:0]           slot_mac [SLOTS];
  logic                  slot_valid [SLOTS] = '{default: 1'b0};
  arp_res_t              pending_results [$];

  int                    mismatch_cnt   = 0;
  int                    quiet_cycles   = 0;
  int                    burst_left     = 0;
  int                    frames_sent    = 0;
  bit                    gaps_on        = 1'b1;
  logic [31:0]           ip_pool [POOL_SIZE];
  logic [47:0]           phase_mac [NUM_PHASES];
  logic [31:0]           phase_ip [NUM_PHASES];

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{1'b1, 7'd0, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, 32'h0, 7'd0, 1'b1, 1'b0, 48'h0},
    '{1'b1, 7'd0, 16'h0, 16'h0, 16'h0, 48'h0, 32'hffff_ffff, 32'h0, 7'd0,
      1'b1, 1'b0, 48'h0},
    '{1'b0, 7'd1, ARP_HTYPE, ARP_PTYPE, ARP_REQ, MAC_A, 32'h0a00_0001, OWN_IP_A, 7'd0,
      1'b0, 1'b0, 48'h0},
    '{1'b0, 7'd41, ARP_HTYPE, ARP_PTYPE, ARP_REQ, MAC_A, 32'h0a00_0001, OWN_IP_A, 7'd0,
      1'b0, 1'b0, 48'h0},
    '{1'b0, 7'd42, ARP_HTYPE, ARP_PTYPE, ARP_REQ, MAC_A, 32'h0a00_0001, OWN_IP_A, 7'd0,
      1'b0, 1'b0, 48'h0},
    '{1'b1, 7'd0, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0a00_0001, 32'h0, 7'd0,
      1'b1, 1'b1, MAC_A},
    '{1'b0, 7'd42, 16'h0006, ARP_PTYPE, ARP_REQ, MAC_B, 32'h0a00_0002, OWN_IP_A, 7'd0,
      1'b0, 1'b0, 48'h0},
    '{1'b1, 7'd0, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0a00_0002, 32'h0, 7'd0,
      1'b1, 1'b0, 48'h0},
    '{1'b0, 7'd43, ARP_HTYPE, ARP_PTYPE, ARP_REQ, MAC_B, 32'h0a00_0001, OWN_IP_A, 7'd20,
      1'b0, 1'b0, 48'h0},
    '{1'b1, 7'd0, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0a00_0001, 32'h0, 7'd0,
      1'b1, 1'b1, MAC_B}
  };

  arp_responder_with_cache #(.TABLE_ENTRIES(SLOTS)) u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic predict_arp_results(input logic rt, input logic [7:0] fb, input logic fl,
                                     input logic [31:0] qip);
    arp_res_t     res;
    logic         full;
    logic         stored;
    logic [47:0]  snd_mac;
    logic [31:0]  snd_ip;
    logic [31:0]  tgt_ip;
    logic [223:0] reply;
    res = '0;
    if (rt == REQ_LOOKUP) begin
      res.kind = RES_LOOKUP;
      for (int i = 0; i < SLOTS; i++) begin
        if (!res.hit && slot_valid[i] && slot_ip[i] == qip) begin
          res.hit = 1'b1;
          res.mac = slot_mac[i];
        end
      end
      pending_results.push_back(res);
      return;
    end
    if (rx_count >= HDR_LEN && rx_count < MIN_FRAME)
      arp_buf[rx_count - HDR_LEN] = fb;
    if (rx_count < MIN_FRAME)
      rx_count++;
    if (!fl)
      return;
    full = rx_count >= MIN_FRAME;
    rx_count = '0;
    if (!full || {arp_buf[0], arp_buf[1]} != ARP_HTYPE || {arp_buf[2], arp_buf[3]} != ARP_PTYPE)
      return;
    snd_mac = {arp_buf[8], arp_buf[9], arp_buf[10], arp_buf[11], arp_buf[12], arp_buf[13]};
    snd_ip  = {arp_buf[14], arp_buf[15], arp_buf[16], arp_buf[17]};
    tgt_ip  = {arp_buf[24], arp_buf[25], arp_buf[26], arp_buf[27]};
    // first free or same-ip slot, dropped when the table is full
    stored = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!stored && (!slot_valid[i] || slot_ip[i] == snd_ip)) begin
        slot_ip[i]    = snd_ip;
        slot_mac[i]   = snd_mac;
        slot_valid[i] = 1'b1;
        stored        = 1'b1;
      end
    end
    if ({arp_buf[6], arp_buf[7]} != ARP_REQ || tgt_ip != cfg_ip)
      return;
    reply = {ARP_HTYPE, ARP_PTYPE, HLEN_ETH, PLEN_IPV4, ARP_REP, cfg_mac, cfg_ip,
             snd_mac, snd_ip};
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      res       = '0;
      res.kind  = RES_REPLY;
      res.rbyte = reply[223 - 8 * i -: 8];
      res.dest  = snd_mac;
      res.last  = (i == PAYLOAD_LEN - 1);
      pending_results.push_back(res);
    end
  endtask

  // request acceptance and result checking
  always @(posedge clk) begin
    arp_res_t want;
    if (!rst && start && !busy) begin
      if (typed_on)
        pending_results.push_back(typed_res);
      else
        predict_arp_results(req_type, frame_byte, frame_last, query_ip);
    end
    if (!rst && strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(result_kind), 64'(RES_REPLY));
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", 64'(result_kind), 64'(want.kind));
        if (reply_byte !== want.rbyte)
          report_mismatch("reply_byte", 64'(reply_byte), 64'(want.rbyte));
        if (reply_dest_mac !== want.dest)
          report_mismatch("reply_dest_mac", 64'(reply_dest_mac), 64'(want.dest));
        if (reply_last !== want.last)
          report_mismatch("reply_last", 64'(reply_last), 64'(want.last));
        if (lookup_hit !== want.hit)
          report_mismatch("lookup_hit", 64'(lookup_hit), 64'(want.hit));
        if (lookup_mac !== want.mac)
          report_mismatch("lookup_mac", 64'(lookup_mac), 64'(want.mac));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe === 1'b1 || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[3] == REG_OWN_MAC)
      cfg_mac = data[47:0];
    else
      cfg_ip = data[31:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_req(input logic rt, input logic [7:0] fb, input logic fl,
                          input logic [31:0] qip, input logic typed = 1'b0,
                          input arp_res_t want = '0);
    int gap;
    if (burst_left == 0) begin
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start      <= 1'b1;
    req_type   <= rt;
    frame_byte <= fb;
    frame_last <= fl;
    query_ip   <= qip;
    typed_on   <= typed;
    typed_res  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_frame(input stim_row_t f);
    logic [223:0] payload;
    logic [7:0]   b;
    payload = {f.htype, f.ptype, HLEN_ETH, PLEN_IPV4, f.oper, f.sha, f.spa, rand48(), f.tpa};
    for (int i = 0; i < f.len; i++) begin
      // a lookup slipped in between frame bytes
      if (f.q_at != 0 && i == f.q_at)
        send_req(REQ_LOOKUP, 8'($urandom), 1'($urandom), f.spa);
      b = (i >= HDR_LEN && i < MIN_FRAME) ? payload[223 - 8 * (i - HDR_LEN) -: 8]
                                          : 8'($urandom);
      send_req(REQ_FRAME, b, i == f.len - 1, 32'($urandom));
    end
  endtask

  task automatic send_random_unit();
    stim_row_t f;
    int        pick;
    int        op_pick;
    f    = '0;
    pick = $urandom_range(0, 99);
    f.spa = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                        : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 35) begin
      send_req(REQ_LOOKUP, 8'($urandom), 1'($urandom), f.spa);
      return;
    end
    f.len   = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(43, 80)) : 7'd42;
    f.htype = ARP_HTYPE;
    f.ptype = ARP_PTYPE;
    op_pick = $urandom_range(0, 19);
    f.oper  = (op_pick < 15) ? ARP_REQ : (op_pick < 18) ? ARP_REP : 16'($urandom);
    f.sha   = rand48();
    f.tpa   = ($urandom_range(0, 9) < 6) ? cfg_ip : 32'($urandom);
    // broken frames: cut short, or a flipped bit in the type fields
    if (pick >= 96)
      f.ptype ^= 16'(1) << $urandom_range(0, 15);
    else if (pick >= 92)
      f.htype ^= 16'(1) << $urandom_range(0, 15);
    else if (pick >= 88)
      f.len = 7'($urandom_range(1, 41));
    if (f.len > 1 && $urandom_range(0, 7) == 0)
      f.q_at = 7'($urandom_range(1, f.len - 1));
    frames_sent++;
    send_frame(f);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    arp_res_t want;
    int       frame_base;
    foreach (ip_pool[i])
      ip_pool[i] = $urandom;
    phase_mac = '{MAC_ONES, 48'h0};
    phase_ip  = '{32'hffff_ffff, 32'h0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(ADDR_OWN_MAC, 64'(OWN_MAC_A));
    write_reg(ADDR_OWN_IP, 64'(OWN_IP_A));

    foreach (directed_rows[r]) begin
      if (directed_rows[r].lookup) begin
        want = {RES_LOOKUP, 8'h00, 48'h0, 1'b0, directed_rows[r].exp_hit,
                directed_rows[r].exp_mac};
        send_req(REQ_LOOKUP, 8'($urandom), 1'($urandom), directed_rows[r].spa,
                 directed_rows[r].typed, want);
      end else begin
        send_frame(directed_rows[r]);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(ADDR_OWN_MAC, 64'(phase_mac[ph]));
      write_reg(ADDR_OWN_IP, 64'(phase_ip[ph]));
      gaps_on    = (ph != 1);
      frame_base = frames_sent;
      while (frames_sent < frame_base + PHASE_FRAMES)
        send_random_unit();
    end

    settle();
    if (mismatch_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
